/* sv/hotplug_motion_sensor_supervisor_assert.svh */
// Assertion macros for the motion sensor supervisor.
// Used by the top level; needs a clock and an active-low reset in scope.
`ifndef HOTPLUG_MOTION_SENSOR_SUPERVISOR_ASSERT_SVH
`define HOTPLUG_MOTION_SENSOR_SUPERVISOR_ASSERT_SVH

// Same-cycle implication.
`define MSUP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("msup check failed");

// Next-cycle implication.
`define MSUP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("msup check failed");

`endif

/* sv/msup_pkg.sv */
// Types, codes and helpers shared by the motion sensor supervisor modules.
// No dependencies.
package msup_pkg;

    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_INIT = 2'd1,
        ACC_READ = 2'd2
    } access_t;

    typedef enum logic [1:0] {
        REG_RETRY_INTERVAL = 2'd0,
        REG_POLL_PERIOD    = 2'd1,
        REG_HEARTBEAT      = 2'd2,
        REG_FAIL_THRESHOLD = 2'd3
    } cfg_index_t;

    localparam logic [15:0] RETRY_INTERVAL_RST = 16'd2000;
    localparam logic [7:0]  POLL_PERIOD_RST    = 8'd2;
    localparam logic [15:0] HEARTBEAT_RST      = 16'd200;
    localparam logic [3:0]  FAIL_THRESHOLD_RST = 4'd3;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 136;

    typedef struct packed {
        logic [15:0] retry_interval_ms;
        logic [7:0]  poll_period_ms;
        logic [15:0] heartbeat_period_ms;
        logic [3:0]  fail_threshold;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               init_ok;
        logic               read_ok;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [7:0]         surface_quality;
        logic [15:0]        shutter_value;
        logic [7:0]         motion_flags;
    } item_t;

    typedef struct packed {
        access_t            access_taken;
        logic               link_up;
        logic               report_valid;
        logic signed [15:0] report_dx;
        logic signed [15:0] report_dy;
        logic [7:0]         report_quality;
        logic [15:0]        report_shutter;
        logic [7:0]         report_motion;
        logic signed [31:0] total_x;
        logic signed [31:0] total_y;
    } result_t;

    function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
        logic [31:0] diff;
        diff = now - deadline;
        return ~diff[31];
    endfunction

endpackage

/* sv/hotplug_motion_sensor_supervisor.sv */
// Top level of the hot-plug motion sensor supervisor: stream ports, input and
// result registers. Depends on msup_pkg, msup_cfg, msup_core and the assert header.
//
// Each input transaction is one pass of the sensor polling loop and yields exactly
// one result transaction. A pass is evaluated combinationally between the input
// register and the result register, so the block takes one transaction per clock
// unless the result register is full and m_tready is low. Throughput is limited
// only by m_tready. Configuration writes take effect on the next clock and must
// be issued while no transaction is in flight.
`include "hotplug_motion_sensor_supervisor_assert.svh"

module hotplug_motion_sensor_supervisor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_ms[31:0], init_ok[32], read_ok[33], delta_x[49:34], delta_y[65:50],
    // surface_quality[73:66], shutter_value[89:74], motion_flags[97:90], zero pad
    input  logic [msup_pkg::IN_DATA_W-1:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // access_taken[1:0], link_up[2], report_valid[3], report_dx[19:4],
    // report_dy[35:20], report_quality[43:36], report_shutter[59:44],
    // report_motion[67:60], total_x[99:68], total_y[131:100], zero pad
    output logic [msup_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic              in_valid_reg;
    msup_pkg::item_t   in_item_reg, in_item_next;
    logic              out_valid_reg;
    msup_pkg::result_t out_result_reg;
    msup_pkg::result_t result;
    msup_pkg::cfg_t    cfg;
    logic              advance;
    logic              in_load;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_load  = s_tvalid && s_tready;

    always_comb begin
        in_item_next.now_ms          = s_tdata[31:0];
        in_item_next.init_ok         = s_tdata[32];
        in_item_next.read_ok         = s_tdata[33];
        in_item_next.delta_x         = s_tdata[49:34];
        in_item_next.delta_y         = s_tdata[65:50];
        in_item_next.surface_quality = s_tdata[73:66];
        in_item_next.shutter_value   = s_tdata[89:74];
        in_item_next.motion_flags    = s_tdata[97:90];
    end

    msup_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msup_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= in_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_result_reg.total_y,
                       out_result_reg.total_x,
                       out_result_reg.report_motion,
                       out_result_reg.report_shutter,
                       out_result_reg.report_quality,
                       out_result_reg.report_dy,
                       out_result_reg.report_dx,
                       out_result_reg.report_valid,
                       out_result_reg.link_up,
                       out_result_reg.access_taken};

    `MSUP_ASSERT_NOW(a_report_needs_read, aclk, aresetn,
        out_valid_reg && out_result_reg.report_valid,
        out_result_reg.access_taken == msup_pkg::ACC_READ && out_result_reg.link_up)
    `MSUP_ASSERT_NOW(a_init_no_report, aclk, aresetn,
        out_valid_reg && out_result_reg.access_taken == msup_pkg::ACC_INIT,
        !out_result_reg.report_valid)
    `MSUP_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, out_valid_reg)
    `MSUP_ASSERT_NOW(a_stall_only_when_full, aclk, aresetn,
        !s_tready, in_valid_reg && out_valid_reg && !m_tready)

endmodule

/* sv/msup_cfg.sv */
// Configuration register file of the motion sensor supervisor.
// Depends on msup_pkg.
module msup_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output msup_pkg::cfg_t      cfg
);

    msup_pkg::cfg_t cfg_reg;
    msup_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (msup_pkg::cfg_index_t'(cfg_index))
                msup_pkg::REG_RETRY_INTERVAL: cfg_next.retry_interval_ms   = cfg_data;
                msup_pkg::REG_POLL_PERIOD:    cfg_next.poll_period_ms      = cfg_data[7:0];
                msup_pkg::REG_HEARTBEAT:      cfg_next.heartbeat_period_ms = cfg_data;
                msup_pkg::REG_FAIL_THRESHOLD: cfg_next.fail_threshold      = cfg_data[3:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retry_interval_ms   <= msup_pkg::RETRY_INTERVAL_RST;
            cfg_reg.poll_period_ms      <= msup_pkg::POLL_PERIOD_RST;
            cfg_reg.heartbeat_period_ms <= msup_pkg::HEARTBEAT_RST;
            cfg_reg.fail_threshold      <= msup_pkg::FAIL_THRESHOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/msup_core.sv */
// Link state, deadlines and position accumulators; one pass per advance.
// Depends on msup_pkg.
module msup_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  msup_pkg::cfg_t      cfg,
    input  msup_pkg::item_t     item,
    output msup_pkg::result_t   result
);

    logic        connected_reg,      connected_next;
    logic [31:0] retry_deadline_reg, retry_deadline_next;
    logic [31:0] poll_deadline_reg,  poll_deadline_next;
    logic [31:0] beat_deadline_reg,  beat_deadline_next;
    logic [3:0]  fail_count_reg,     fail_count_next;
    logic [31:0] position_x_reg,     position_x_next;
    logic [31:0] position_y_reg,     position_y_next;

    logic        retry_hit;
    logic        poll_hit;
    logic        beat_hit;
    logic        moved;
    logic        report;
    logic [3:0]  fail_inc;
    logic [31:0] now_plus_retry;
    msup_pkg::access_t access;

    assign retry_hit      = msup_pkg::reached(item.now_ms, retry_deadline_reg);
    assign poll_hit       = msup_pkg::reached(item.now_ms, poll_deadline_reg);
    assign beat_hit       = msup_pkg::reached(item.now_ms, beat_deadline_reg);
    assign moved          = (item.delta_x != 16'sd0) || (item.delta_y != 16'sd0);
    assign fail_inc       = fail_count_reg + 4'd1;
    assign now_plus_retry = item.now_ms + {16'd0, cfg.retry_interval_ms};

    always_comb begin
        connected_next      = connected_reg;
        retry_deadline_next = retry_deadline_reg;
        poll_deadline_next  = poll_deadline_reg;
        beat_deadline_next  = beat_deadline_reg;
        fail_count_next     = fail_count_reg;
        position_x_next     = position_x_reg;
        position_y_next     = position_y_reg;
        access              = msup_pkg::ACC_NONE;
        report              = 1'b0;
        if (!connected_reg) begin
            if (retry_hit) begin
                access              = msup_pkg::ACC_INIT;
                retry_deadline_next = now_plus_retry;
                if (item.init_ok) begin
                    connected_next  = 1'b1;
                    fail_count_next = 4'd0;
                    position_x_next = 32'd0;
                    position_y_next = 32'd0;
                end
            end
        end else if (poll_hit) begin
            access             = msup_pkg::ACC_READ;
            poll_deadline_next = item.now_ms + {24'd0, cfg.poll_period_ms};
            if (!item.read_ok) begin
                fail_count_next = fail_inc;
                if (fail_inc >= cfg.fail_threshold) begin
                    connected_next      = 1'b0;
                    fail_count_next     = 4'd0;
                    retry_deadline_next = now_plus_retry;
                end
            end else begin
                fail_count_next = 4'd0;
                position_x_next = position_x_reg + {{16{item.delta_x[15]}}, item.delta_x};
                position_y_next = position_y_reg + {{16{item.delta_y[15]}}, item.delta_y};
                if (beat_hit) begin
                    beat_deadline_next = item.now_ms + {16'd0, cfg.heartbeat_period_ms};
                end
                report = moved || beat_hit;
            end
        end
    end

    always_comb begin
        result.access_taken   = access;
        result.link_up        = connected_next;
        result.report_valid   = report;
        result.report_dx      = report ? item.delta_x         : 16'sd0;
        result.report_dy      = report ? item.delta_y         : 16'sd0;
        result.report_quality = report ? item.surface_quality : 8'd0;
        result.report_shutter = report ? item.shutter_value   : 16'd0;
        result.report_motion  = report ? item.motion_flags    : 8'd0;
        result.total_x        = position_x_next;
        result.total_y        = position_y_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            connected_reg      <= 1'b0;
            retry_deadline_reg <= 32'd0;
            poll_deadline_reg  <= 32'd0;
            beat_deadline_reg  <= 32'd0;
            fail_count_reg     <= 4'd0;
            position_x_reg     <= 32'd0;
            position_y_reg     <= 32'd0;
        end else if (advance) begin
            connected_reg      <= connected_next;
            retry_deadline_reg <= retry_deadline_next;
            poll_deadline_reg  <= poll_deadline_next;
            beat_deadline_reg  <= beat_deadline_next;
            fail_count_reg     <= fail_count_next;
            position_x_reg     <= position_x_next;
            position_y_reg     <= position_y_next;
        end
    end

endmodule

/* tb/hotplug_motion_sensor_supervisor_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for hotplug_motion_sensor_supervisor: sends loop passes on the
// input stream and compares every result transaction with an in-bench supervisor model.
// Depends on msup_pkg and the supervisor RTL.
module hotplug_motion_sensor_supervisor_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [103:0]         s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [135:0]         m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    msup_pkg::cfg_index_t cfg_index = msup_pkg::REG_RETRY_INTERVAL;
    logic [15:0]          cfg_data = '0;

    // supervisor model
    msup_pkg::cfg_t    settings;
    logic              linked;
    logic [31:0]       retry_due;
    logic [31:0]       poll_due;
    logic [31:0]       beat_due;
    logic [3:0]        miss_count;
    logic [31:0]       pos_x;
    logic [31:0]       pos_y;
    msup_pkg::result_t pending_results[$];

    logic [31:0] loop_ms = '0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_request = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int n_passes = 0;
    int n_inits = 0;
    int n_reads = 0;
    int n_reports = 0;
    int n_drops = 0;
    int n_reg_writes = 0;

    hotplug_motion_sensor_supervisor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic deadline_hit(input logic [31:0] now, input logic [31:0] due);
        return $signed(now - due) >= 0;
    endfunction

    function automatic msup_pkg::result_t run_pass(input msup_pkg::item_t p);
        msup_pkg::result_t r;
        logic              moved;
        logic              beat;
        r = '0;
        r.access_taken = msup_pkg::ACC_NONE;
        if (!linked) begin
            if (deadline_hit(p.now_ms, retry_due)) begin
                r.access_taken = msup_pkg::ACC_INIT;
                n_inits++;
                if (p.init_ok) begin
                    linked = 1'b1;
                    miss_count = '0;
                    pos_x = '0;
                    pos_y = '0;
                end
                retry_due = p.now_ms + settings.retry_interval_ms;
            end
        end else if (deadline_hit(p.now_ms, poll_due)) begin
            r.access_taken = msup_pkg::ACC_READ;
            n_reads++;
            poll_due = p.now_ms + settings.poll_period_ms;
            if (!p.read_ok) begin
                miss_count = miss_count + 4'd1;
                if (miss_count >= settings.fail_threshold) begin
                    linked = 1'b0;
                    miss_count = '0;
                    retry_due = p.now_ms + settings.retry_interval_ms;
                    n_drops++;
                end
            end else begin
                miss_count = '0;
                pos_x = pos_x + {{16{p.delta_x[15]}}, p.delta_x};
                pos_y = pos_y + {{16{p.delta_y[15]}}, p.delta_y};
                moved = (p.delta_x != 0) || (p.delta_y != 0);
                beat = deadline_hit(p.now_ms, beat_due);
                if (beat) begin
                    beat_due = p.now_ms + settings.heartbeat_period_ms;
                end
                if (moved || beat) begin
                    r.report_valid = 1'b1;
                    r.report_dx = p.delta_x;
                    r.report_dy = p.delta_y;
                    r.report_quality = p.surface_quality;
                    r.report_shutter = p.shutter_value;
                    r.report_motion = p.motion_flags;
                    n_reports++;
                end
            end
        end
        r.link_up = linked;
        r.total_x = pos_x;
        r.total_y = pos_y;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic msup_pkg::item_t fixed_pass(input logic [31:0] now,
                                                   input logic init_ok,
                                                   input logic read_ok,
                                                   input logic [15:0] dx,
                                                   input logic [15:0] dy);
        msup_pkg::item_t p;
        p.now_ms = now;
        p.init_ok = init_ok;
        p.read_ok = read_ok;
        p.delta_x = dx;
        p.delta_y = dy;
        p.surface_quality = 8'($urandom());
        p.shutter_value = 16'($urandom());
        p.motion_flags = 8'($urandom());
        return p;
    endfunction

    function automatic msup_pkg::item_t random_pass(input logic [31:0] now, input logic miss);
        logic [15:0] dx;
        logic [15:0] dy;
        case ($urandom_range(3))
            0: begin
                dx = '0;
                dy = '0;
            end
            1: begin
                dx = 16'($urandom_range(16)) - 16'd8;
                dy = 16'($urandom_range(16)) - 16'd8;
            end
            2: begin
                dx = 16'($urandom());
                dy = '0;
            end
            default: begin
                dx = 16'($urandom());
                dy = 16'($urandom());
            end
        endcase
        return fixed_pass(now, $urandom_range(99) < 70, !miss && ($urandom_range(99) < 90),
                          dx, dy);
    endfunction

    task automatic send_pass(input msup_pkg::item_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, p.motion_flags, p.shutter_value, p.surface_quality,
                    p.delta_y, p.delta_x, p.read_ok, p.init_ok, p.now_ms};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(run_pass(p));
        n_passes++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [15:0] retry, input logic [7:0] poll,
                                  input logic [15:0] beat, input logic [3:0] thresh);
        msup_pkg::cfg_index_t idx;
        logic [15:0]          val;
        wait_results_done();
        for (int i = 0; i < 4; i++) begin
            idx = msup_pkg::cfg_index_t'(i);
            case (idx)
                msup_pkg::REG_RETRY_INTERVAL: begin
                    val = retry;
                    settings.retry_interval_ms = retry;
                end
                msup_pkg::REG_POLL_PERIOD: begin
                    val = {8'd0, poll};
                    settings.poll_period_ms = poll;
                end
                msup_pkg::REG_HEARTBEAT: begin
                    val = beat;
                    settings.heartbeat_period_ms = beat;
                end
                default: begin
                    val = {12'd0, thresh};
                    settings.fail_threshold = thresh;
                end
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            n_reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int count, input int step_max);
        int outage;
        outage = 0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 2) begin
                loop_ms = $urandom();
            end else begin
                loop_ms = loop_ms + $urandom_range(step_max);
            end
            if (outage > 0) begin
                outage--;
            end else if ($urandom_range(99) < 4) begin
                outage = $urandom_range(1, 16);
            end
            send_pass(random_pass(loop_ms, outage > 0));
        end
    endtask

    task automatic test_reset_defaults();
        msup_pkg::item_t p;
        // upper half of the time range: retry deadline 0 not yet reached
        send_pass(fixed_pass(32'h8000_0000, 1'b1, 1'b1, 16'h0000, 16'h0000));
        send_pass(fixed_pass(32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0005, 16'h0005));
        send_pass(fixed_pass(32'd5, 1'b0, 1'b1, 16'h7FFF, 16'h0001));
        send_pass(fixed_pass(32'd100, 1'b1, 1'b1, 16'h0000, 16'h0000));
        send_pass(fixed_pass(32'd2005, 1'b1, 1'b1, 16'h0003, 16'hFFFD));
        send_pass(fixed_pass(32'd2006, 1'b0, 1'b1, 16'h0000, 16'h0000));
        send_pass(fixed_pass(32'd2007, 1'b0, 1'b1, 16'h0009, 16'h0009));
        p = fixed_pass(32'd2008, 1'b0, 1'b1, 16'h8000, 16'h7FFF);
        p.surface_quality = 8'hFF;
        p.shutter_value = 16'hFFFF;
        p.motion_flags = 8'hFF;
        send_pass(p);
        send_pass(fixed_pass(32'd2010, 1'b1, 1'b1, 16'h0000, 16'h0000));
        p = fixed_pass(32'd2012, 1'b0, 1'b1, 16'h7FFF, 16'h8000);
        p.surface_quality = 8'h00;
        p.shutter_value = 16'h0000;
        p.motion_flags = 8'h00;
        send_pass(p);
        send_pass(fixed_pass(32'd2014, 1'b1, 1'b0, 16'h0001, 16'h0001));
        send_pass(fixed_pass(32'd2016, 1'b1, 1'b0, 16'h0001, 16'h0001));
        send_pass(fixed_pass(32'd2018, 1'b1, 1'b1, 16'h0002, 16'h0000));
        send_pass(fixed_pass(32'd2020, 1'b1, 1'b0, 16'h0000, 16'h0000));
        send_pass(fixed_pass(32'd2022, 1'b1, 1'b0, 16'h0000, 16'h0000));
        send_pass(fixed_pass(32'd2024, 1'b1, 1'b0, 16'h0000, 16'h0000));
        send_pass(fixed_pass(32'd2030, 1'b1, 1'b1, 16'h0000, 16'h0000));
        send_pass(fixed_pass(32'd4024, 1'b0, 1'b1, 16'h0004, 16'h0004));
        send_pass(fixed_pass(32'd6024, 1'b1, 1'b1, 16'h0004, 16'h0004));
        send_pass(fixed_pass(32'd6024, 1'b0, 1'b1, 16'h0000, 16'h0000));
        send_pass(fixed_pass(32'd6026, 1'b0, 1'b0, 16'h0000, 16'h0000));
        loop_ms = 32'd6030;
    endtask

    task automatic test_extreme_settings();
        write_settings(16'hFFFF, 8'hFF, 16'hFFFF, 4'hF);
        loop_ms = 32'hFFFF_0000;
        run_traffic(60, 3000);
        write_settings(16'h0000, 8'h00, 16'h0000, 4'h0);
        run_traffic(40, 2);
        write_settings(16'h0001, 8'h01, 16'h0001, 4'h1);
        run_traffic(40, 3);
    endtask

    task automatic test_random_settings(input int rounds, input int per_round);
        int step_max;
        for (int r = 0; r < rounds; r++) begin
            case ($urandom_range(2))
                0: write_settings(16'($urandom_range(64)), 8'($urandom_range(8)),
                                  16'($urandom_range(64)), 4'($urandom_range(4)));
                1: write_settings(16'($urandom_range(3000)), 8'($urandom()),
                                  16'($urandom_range(3000)), 4'($urandom()));
                default: write_settings(16'($urandom()), 8'($urandom()),
                                        16'($urandom()), 4'($urandom()));
            endcase
            step_max = (settings.retry_interval_ms >> 3) + settings.poll_period_ms + 2;
            run_traffic(per_round, step_max);
        end
    endtask

    task automatic test_backpressure();
        // hold the sender until the pipeline is empty, then stall the receiver
        wait_results_done();
        stall_request = 80;
        run_traffic(40, 3);
        wait_results_done();
        run_traffic(20, 3);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (stall_request > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_request - 1;
            stall_request = 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        msup_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no pass outstanding");
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("access_taken", want.access_taken, m_tdata[1:0]);
                check_field("link_up", want.link_up, m_tdata[2]);
                check_field("report_valid", want.report_valid, m_tdata[3]);
                check_field("report_dx", want.report_dx, $signed(m_tdata[19:4]));
                check_field("report_dy", want.report_dy, $signed(m_tdata[35:20]));
                check_field("report_quality", want.report_quality, m_tdata[43:36]);
                check_field("report_shutter", want.report_shutter, m_tdata[59:44]);
                check_field("report_motion", want.report_motion, m_tdata[67:60]);
                check_field("total_x", want.total_x, m_tdata[99:68]);
                check_field("total_y", want.total_y, m_tdata[131:100]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[hotplug_motion_sensor_supervisor] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        settings.retry_interval_ms = msup_pkg::RETRY_INTERVAL_RST;
        settings.poll_period_ms = msup_pkg::POLL_PERIOD_RST;
        settings.heartbeat_period_ms = msup_pkg::HEARTBEAT_RST;
        settings.fail_threshold = msup_pkg::FAIL_THRESHOLD_RST;
        linked = 1'b0;
        retry_due = '0;
        poll_due = '0;
        beat_due = '0;
        miss_count = '0;
        pos_x = '0;
        pos_y = '0;
        send_idle_pct = 36;
        recv_idle_pct = 79;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_extreme_settings();
        test_random_settings(8, 45);
        send_idle_pct = 79;
        recv_idle_pct = 36;
        test_random_settings(9, 45);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_settings(9, 45);
        test_backpressure();

        wait_results_done();
        repeat (8) @(posedge aclk);
        $display("Covered %0d passes over %0d register writes: %0d init attempts, %0d reads,",
                 n_passes, n_reg_writes, n_inits, n_reads);
        $display("%0d reports and %0d link drops, with stalls on both streams.",
                 n_reports, n_drops);
        if (errors == 0) begin
            $display("[hotplug_motion_sensor_supervisor] OK");
        end else begin
            $display("[hotplug_motion_sensor_supervisor] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/msup_pkg.sv
sv/msup_cfg.sv
sv/msup_core.sv
sv/hotplug_motion_sensor_supervisor.sv
tb/hotplug_motion_sensor_supervisor_tb.sv
